@@ sv/csf_pkg.sv @@
// Shared types and constants for the COBS sample framer.
package csf_pkg;

    // Width of the internal slot and code counters (counters wrap at 256)
    localparam int SLOT_W = 8;
    // Width of a byte index on the result channel
    localparam int INDEX_W = 7;
    // Width of one byte
    localparam int BYTE_W = 8;
    // Width of one input sample
    localparam int SAMPLE_W = 16;
    // Most byte writes one sample can cause
    localparam int MAX_WRITES = 4;
    localparam int POS_W = 2;

    // Position of the last write in a bundle, without and with a frame close
    localparam logic [POS_W-1:0] POS_PLAIN_LAST = 2'd1;
    localparam logic [POS_W-1:0] POS_CLOSE_LAST = 2'd3;

    // Initial values of the encoder state
    localparam logic [SLOT_W-1:0] RUN_CODE_INIT   = 8'd1;
    localparam logic [SLOT_W-1:0] CODE_SLOT_INIT  = 8'd0;
    localparam logic [SLOT_W-1:0] WRITE_SLOT_INIT = 8'd1;

    // All byte writes caused by one sample
    typedef struct packed {
        logic                           buffer_sel;
        logic                           close;
        logic [MAX_WRITES-1:0][SLOT_W-1:0] index;
        logic [MAX_WRITES-1:0][BYTE_W-1:0] value;
    } csf_bundle_t;

    // COBS state after one byte
    typedef struct packed {
        logic [SLOT_W-1:0] run_code;
        logic [SLOT_W-1:0] code_slot;
        logic [SLOT_W-1:0] write_slot;
    } csf_cobs_t;

    // Encode one byte: returns the new state; index and value of the write
    // come from the state before the byte.
    function automatic csf_cobs_t cobs_advance(csf_cobs_t st, logic [BYTE_W-1:0] b);
        csf_cobs_t nx;
        nx.write_slot = st.write_slot + 8'd1;
        if (b == '0) begin
            nx.code_slot = st.write_slot;
            nx.run_code  = RUN_CODE_INIT;
        end else begin
            nx.code_slot = st.code_slot;
            nx.run_code  = st.run_code + 8'd1;
        end
        return nx;
    endfunction

    function automatic logic [SLOT_W-1:0] cobs_index(csf_cobs_t st, logic [BYTE_W-1:0] b);
        return (b == '0) ? st.code_slot : st.write_slot;
    endfunction

    function automatic logic [BYTE_W-1:0] cobs_value(csf_cobs_t st, logic [BYTE_W-1:0] b);
        return (b == '0) ? st.run_code : b;
    endfunction

endpackage

@@ sv/csf_encoder.sv @@
// Input register and COBS encoder state: turns one sample into a write bundle.
module csf_encoder #(
    parameter int FRAME_BYTES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csf_pkg::SAMPLE_W-1:0]  s_tdata,
    output logic                          bundle_valid,
    input  logic                          bundle_ready,
    output csf_pkg::csf_bundle_t          bundle
);

    localparam logic [csf_pkg::SLOT_W-1:0] FRAME_LIMIT = csf_pkg::SLOT_W'(FRAME_BYTES);
    localparam logic [csf_pkg::SLOT_W-1:0] DELIM_INDEX = csf_pkg::SLOT_W'(FRAME_BYTES + 1);

    logic                          in_valid_reg;
    logic [csf_pkg::SAMPLE_W-1:0]  sample_reg;
    csf_pkg::csf_cobs_t            cobs_reg, cobs_next;
    logic [csf_pkg::SLOT_W-1:0]    payload_count_reg, payload_count_next;
    logic                          active_buffer_reg, active_buffer_next;

    csf_pkg::csf_cobs_t            cobs_mid, cobs_end;
    logic [csf_pkg::BYTE_W-1:0]    byte_lo, byte_hi;
    logic [csf_pkg::SLOT_W-1:0]    count_sum;
    logic                          close;
    logic                          handoff;

    assign s_tready     = !in_valid_reg || bundle_ready;
    assign bundle_valid = in_valid_reg;
    assign handoff      = in_valid_reg && bundle_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (handoff) begin
            in_valid_reg <= 1'b0;
        end
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata;
        end
    end

    // Encode both bytes of the sample, low byte first
    always_comb begin
        byte_lo   = sample_reg[csf_pkg::BYTE_W-1:0];
        byte_hi   = sample_reg[csf_pkg::SAMPLE_W-1:csf_pkg::BYTE_W];
        cobs_mid  = csf_pkg::cobs_advance(cobs_reg, byte_lo);
        cobs_end  = csf_pkg::cobs_advance(cobs_mid, byte_hi);
        count_sum = payload_count_reg + 8'd2;
        close     = (count_sum >= FRAME_LIMIT);

        bundle.buffer_sel = active_buffer_reg;
        bundle.close      = close;
        bundle.index[0]   = csf_pkg::cobs_index(cobs_reg, byte_lo);
        bundle.value[0]   = csf_pkg::cobs_value(cobs_reg, byte_lo);
        bundle.index[1]   = csf_pkg::cobs_index(cobs_mid, byte_hi);
        bundle.value[1]   = csf_pkg::cobs_value(cobs_mid, byte_hi);
        // final code byte, then the delimiter
        bundle.index[2]   = cobs_end.code_slot;
        bundle.value[2]   = cobs_end.run_code;
        bundle.index[3]   = DELIM_INDEX;
        bundle.value[3]   = '0;

        if (close) begin
            cobs_next.run_code   = csf_pkg::RUN_CODE_INIT;
            cobs_next.code_slot  = csf_pkg::CODE_SLOT_INIT;
            cobs_next.write_slot = csf_pkg::WRITE_SLOT_INIT;
            payload_count_next   = '0;
            active_buffer_next   = !active_buffer_reg;
        end else begin
            cobs_next            = cobs_end;
            payload_count_next   = count_sum;
            active_buffer_next   = active_buffer_reg;
        end
    end

    // Encoder state advances when the bundle is handed on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cobs_reg.run_code   <= csf_pkg::RUN_CODE_INIT;
            cobs_reg.code_slot  <= csf_pkg::CODE_SLOT_INIT;
            cobs_reg.write_slot <= csf_pkg::WRITE_SLOT_INIT;
            payload_count_reg   <= '0;
            active_buffer_reg   <= 1'b0;
        end else if (handoff) begin
            cobs_reg            <= cobs_next;
            payload_count_reg   <= payload_count_next;
            active_buffer_reg   <= active_buffer_next;
        end
    end

`ifndef SYNTH
    // A closing sample swaps buffers and restarts the frame
    a_close_swaps: assert property (@(posedge aclk) disable iff (!aresetn)
        handoff && close |=> active_buffer_reg != $past(active_buffer_reg)
                              && payload_count_reg == '0)
        else $error("frame close did not swap buffer");

    // Payload count never passes the frame limit between samples
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        payload_count_reg < FRAME_LIMIT)
        else $error("payload count beyond frame size");
`endif

endmodule

@@ sv/csf_serializer.sv @@
// Result register: issues the writes of one bundle one item per cycle while m_tready is high.
module csf_serializer (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       bundle_valid,
    output logic                       bundle_ready,
    input  csf_pkg::csf_bundle_t       bundle,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    logic                          busy_reg;
    logic [csf_pkg::POS_W-1:0]     pos_reg;
    csf_pkg::csf_bundle_t          bundle_reg;
    logic [csf_pkg::POS_W-1:0]     last_pos;
    logic                          out_fire;
    logic                          final_fire;
    logic                          load;

    assign last_pos     = bundle_reg.close ? csf_pkg::POS_CLOSE_LAST
                                           : csf_pkg::POS_PLAIN_LAST;
    assign out_fire     = busy_reg && m_tready;
    assign final_fire   = out_fire && (pos_reg == last_pos);
    assign bundle_ready = !busy_reg || final_fire;
    assign load         = bundle_valid && bundle_ready;

    // Bundle register and write position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end else if (final_fire) begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end else if (out_fire) begin
            pos_reg  <= pos_reg + 2'd1;
        end
        if (load) begin
            bundle_reg <= bundle;
        end
    end

    // Current write onto the result channel
    assign m_tvalid = busy_reg;
    assign m_tdata  = {bundle_reg.value[pos_reg],
                       bundle_reg.index[pos_reg][csf_pkg::INDEX_W-1:0],
                       bundle_reg.buffer_sel};
    assign m_tuser  = bundle_reg.close && (pos_reg == csf_pkg::POS_CLOSE_LAST);
    assign m_tlast  = (pos_reg == last_pos);

`ifndef SYNTH
    // Frame done only on the last write of a sample
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tuser |-> m_tlast)
        else $error("frame done on a non-final write");

    // The delimiter write carries a zero byte
    a_delim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && m_tuser |-> m_tdata[15:8] == '0)
        else $error("delimiter byte not zero");

    // A freshly loaded bundle starts at its first write
    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> busy_reg && pos_reg == '0)
        else $error("bundle load did not restart position");
`endif

endmodule

@@ sv/cobs_sample_framer.sv @@
// Top level of the COBS sample framer: input register, encoder, write serializer.
//
// Usage:
//   s_ channel: one 16-bit sample per item, low byte encoded first.
//   m_ channel: one byte write per item into one of two ping-pong frame
//   buffers. tdata = {byte_value[15:8], byte_index[7:1], buffer_sel[0]},
//   tuser = frame_done (on the zero delimiter that ends a frame),
//   tlast = final write caused by the sample.
//   A sample causes two writes, or four when it completes a frame (final
//   code byte at the reserved slot, then a zero at FRAME_BYTES+1); after
//   that the other buffer is filled.
//   A sample passes the input register, then its bundle is loaded into
//   the serializer's bundle register, from which the result port issues
//   one write per cycle while m_tready is high. The next sample is taken
//   while the current writes drain.
//   Reset (aresetn low, synchronous) empties both registers and restarts
//   the encoder on the first buffer at index 0.
//   When m_tready is low, the current write holds and the input register
//   fills, after which s_tready drops.
module cobs_sample_framer #(
    parameter int FRAME_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] buffer_sel, [7:1] byte_index, [15:8] byte_value
    output logic        m_tuser,   // [0] frame_done
    output logic        m_tlast
);

    logic                  bundle_valid;
    logic                  bundle_ready;
    csf_pkg::csf_bundle_t  bundle;

    csf_encoder #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_encoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .bundle_valid (bundle_valid),
        .bundle_ready (bundle_ready),
        .bundle       (bundle)
    );

    csf_serializer u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bundle_valid (bundle_valid),
        .bundle_ready (bundle_ready),
        .bundle       (bundle),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
